[hw/rtl/stkf_pkg.sv]
// Shared constants and types for the streaming top-k frequency counter.
// Used by stkf_cell and stream_top_k_frequent; depends on nothing else.
package stkf_pkg;

	localparam int ENTRIES = 64;
	localparam int MAX_K = 8;

	localparam int VAL_W = 16;
	localparam int COUNT_W = 16;
	localparam int TOPC_W = 4;
	localparam int RANK_W = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam int HELD_W = $clog2(ENTRIES + 1);
	localparam int RD_N = (MAX_K < ENTRIES) ? MAX_K : ENTRIES;
	localparam int RD_W = (RD_N > 1) ? $clog2(RD_N) : 1;
	localparam int NUM_W = RD_W + 1;

	typedef struct packed {
		logic clear;
		logic upd;
	} cell_ctl_t;

endpackage

[hw/rtl/stream_top_k_frequent.sv]
// Streaming top-k frequency counter: top level with the cell row, control and output register.
// Depends on stkf_pkg and stkf_cell.
//
// Each accepted word is counted in a row of ENTRIES cells kept sorted by count descending and
// value ascending, so the ranking is always ready at the head of the row. Each word passes
// through these steps before the next word is accepted: its acceptance, a match of the value
// against every cell, an update in which the row shifts by one place to move the updated
// entry to its new rank, and then n result words, one per cycle while the receiver does not
// stall, where n is the smaller of top_count (at least 1, at most MAX_K) and the number of
// distinct values held. With a full table and a new value, the value is dropped and its
// results carry table_full. Reset clears the valid bits at once, so no clearing pass is
// needed; a new_stream word empties the table in the cycle it is accepted.
module stream_top_k_frequent import stkf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [TOPC_W-1:0]  cfg_wdata,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic [VAL_W-1:0]   sample_value,
	input  logic               new_stream,
	output logic               ranked_valid,
	input  logic               ranked_stall,
	output logic [VAL_W-1:0]   ranked_value,
	output logic [COUNT_W-1:0] ranked_count,
	output logic [RANK_W-1:0]  rank,
	output logic               last,
	output logic               table_full
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_MATCH  = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	logic [1:0]         state_q;
	logic [TOPC_W-1:0]  top_count_q;
	logic [VAL_W-1:0]   key_value_q;
	logic [COUNT_W-1:0] key_count_q;
	logic [ENTRIES-1:0] tgt_q;
	logic [ENTRIES-1:0] le_q;
	logic               drop_q;
	logic               miss_q;
	logic [HELD_W-1:0]  held_q;
	logic [NUM_W-1:0]   num_q;
	logic [RD_W-1:0]    r_q;

	logic               out_valid_q;
	logic [VAL_W-1:0]   out_value_q;
	logic [COUNT_W-1:0] out_count_q;
	logic [RANK_W-1:0]  out_rank_q;
	logic               out_last_q;
	logic               out_full_q;

	logic [VAL_W-1:0]   cell_value [ENTRIES];
	logic [COUNT_W-1:0] cell_count [ENTRIES];
	logic [ENTRIES-1:0] valid_vec;
	logic [ENTRIES-1:0] zone_vec;

	cell_ctl_t          ctl;
	logic               accept;
	logic [ENTRIES-1:0] hit_vec;
	logic [ENTRIES-1:0] free_vec;
	logic [ENTRIES-1:0] tgt_c;
	logic               any_hit;
	logic               full_c;
	logic [COUNT_W-1:0] hit_count;
	logic [COUNT_W-1:0] key_count_c;
	logic [HELD_W-1:0]  held_next;
	logic [NUM_W-1:0]   want_c;
	logic [NUM_W-1:0]   num_c;
	logic               out_free;
	logic               load;
	logic               last_c;
	logic [VAL_W-1:0]   rd_value [RD_N];
	logic [COUNT_W-1:0] rd_count [RD_N];

	assign accept = sample_valid && !sample_stall;
	assign sample_stall = (state_q != ST_IDLE);
	assign ctl.clear = accept && new_stream;
	assign ctl.upd = (state_q == ST_UPDATE) && !drop_q;

	genvar gi;
	generate
		for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				stkf_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctl        (ctl),
					.key_value  (key_value_q),
					.key_count  (key_count_q),
					.is_target  (tgt_q[gi]),
					.le_target  (le_q[gi]),
					.left_value ({VAL_W{1'b0}}),
					.left_count ({COUNT_W{1'b0}}),
					.left_valid (1'b0),
					.left_zone  (1'b0),
					.value      (cell_value[gi]),
					.count      (cell_count[gi]),
					.valid      (valid_vec[gi]),
					.zone       (zone_vec[gi])
				);
			end else begin : g_body
				stkf_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctl        (ctl),
					.key_value  (key_value_q),
					.key_count  (key_count_q),
					.is_target  (tgt_q[gi]),
					.le_target  (le_q[gi]),
					.left_value (cell_value[gi-1]),
					.left_count (cell_count[gi-1]),
					.left_valid (valid_vec[gi-1]),
					.left_zone  (zone_vec[gi-1]),
					.value      (cell_value[gi]),
					.count      (cell_count[gi]),
					.valid      (valid_vec[gi]),
					.zone       (zone_vec[gi])
				);
			end
		end
		for (gi = 0; gi < RD_N; gi++) begin : g_rd
			assign rd_value[gi] = cell_value[gi];
			assign rd_count[gi] = cell_count[gi];
		end
	endgenerate

	// The row keeps its valid entries packed at the head, so the first free cell sits
	// just after the last valid one.
	always_comb begin
		hit_count = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec[i] = valid_vec[i] && (cell_value[i] == key_value_q);
			if (i == 0) begin
				free_vec[i] = !valid_vec[i];
			end else begin
				free_vec[i] = valid_vec[i-1] && !valid_vec[i];
			end
			hit_count = hit_count | (hit_vec[i] ? cell_count[i] : {COUNT_W{1'b0}});
		end
	end

	assign any_hit = |hit_vec;
	assign full_c = &valid_vec;
	assign tgt_c = any_hit ? hit_vec : (full_c ? {ENTRIES{1'b0}} : free_vec);
	assign key_count_c = !any_hit ? COUNT_W'(1) :
		(hit_count == COUNT_MAX) ? COUNT_MAX : hit_count + COUNT_W'(1);

	assign held_next = held_q + HELD_W'(miss_q && !drop_q);

	always_comb begin
		if (top_count_q == '0) begin
			want_c = NUM_W'(1);
		end else if (32'(top_count_q) > RD_N) begin
			want_c = NUM_W'(RD_N);
		end else begin
			want_c = NUM_W'(top_count_q);
		end
		if (32'(held_next) < 32'(want_c)) begin
			num_c = NUM_W'(held_next);
		end else begin
			num_c = want_c;
		end
	end

	assign out_free = !out_valid_q || !ranked_stall;
	assign load = (state_q == ST_EMIT) && out_free;
	assign last_c = (({1'b0, r_q} + NUM_W'(1)) == num_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			top_count_q <= TOPC_W'(1);
			held_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				top_count_q <= cfg_wdata;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MATCH;
						if (new_stream) begin
							held_q <= '0;
						end
					end
				end
				ST_MATCH: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					held_q <= held_next;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load && last_c) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_value_q <= sample_value;
		end
		if (state_q == ST_MATCH) begin
			key_count_q <= key_count_c;
			tgt_q <= tgt_c;
			le_q <= tgt_c | (tgt_c - ENTRIES'(1));
			drop_q <= !any_hit && full_c;
			miss_q <= !any_hit;
		end
		if (state_q == ST_UPDATE) begin
			num_q <= num_c;
			r_q <= '0;
		end else if (load) begin
			r_q <= r_q + RD_W'(1);
		end
		if (load) begin
			out_value_q <= rd_value[r_q];
			out_count_q <= rd_count[r_q];
			out_rank_q <= RANK_W'(r_q);
			out_last_q <= last_c;
			out_full_q <= drop_q;
		end
	end

	assign ranked_valid = out_valid_q;
	assign ranked_value = out_value_q;
	assign ranked_count = out_count_q;
	assign rank = out_rank_q;
	assign last = out_last_q;
	assign table_full = out_full_q;

	a_tgt_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPDATE |-> $onehot0(tgt_q))
		else $error("More than one cell selected for update.");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && drop_q) |-> (&valid_vec))
		else $error("Value dropped while a cell was free.");

	a_held_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> (32'(held_q) == $countones(valid_vec)))
		else $error("Held count disagrees with the valid cells.");

	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> ((valid_vec & (valid_vec + ENTRIES'(1))) == '0))
		else $error("Valid cells are not packed at the head of the row.");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && last_c) |=> (state_q == ST_IDLE))
		else $error("Final word did not end the item.");

endmodule

[hw/rtl/stkf_cell.sv]
// One cell of the sorted frequency list: holds a value, its count and a valid bit.
// Takes its left neighbor's entry or the broadcast key when the list shifts.
// Depends on stkf_pkg.
module stkf_cell import stkf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctl_t          ctl,
	input  logic [VAL_W-1:0]   key_value,
	input  logic [COUNT_W-1:0] key_count,
	input  logic               is_target,
	input  logic               le_target,
	input  logic [VAL_W-1:0]   left_value,
	input  logic [COUNT_W-1:0] left_count,
	input  logic               left_valid,
	input  logic               left_zone,
	output logic [VAL_W-1:0]   value,
	output logic [COUNT_W-1:0] count,
	output logic               valid,
	output logic               zone
);

	logic [VAL_W-1:0]   value_q;
	logic [COUNT_W-1:0] count_q;
	logic               valid_q;
	logic               after_key;

	assign after_key = !valid_q || (count_q < key_count) ||
		((count_q == key_count) && (value_q > key_value));
	assign zone = le_target && (is_target || after_key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.upd && zone) begin
			valid_q <= left_zone ? left_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd && zone) begin
			if (left_zone) begin
				value_q <= left_value;
				count_q <= left_count;
			end else begin
				value_q <= key_value;
				count_q <= key_count;
			end
		end
	end

	assign value = value_q;
	assign count = count_q;
	assign valid = valid_q;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for stream_top_k_frequent: a table of directed words, then random words,
// with every ranked word compared against a running top-k frequency predictor kept in the bench.
// Depends on stkf_pkg and the block's RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import stkf_pkg::*;

	localparam int CYCLE_LIMIT = 200_000;
	localparam int HOLD_CYCLES = 300;
	localparam int PLAN_N = 17;
	localparam int SHOW_MAX = 10;

	typedef struct packed {
		logic [VAL_W-1:0]   value;
		logic [COUNT_W-1:0] count;
		logic [RANK_W-1:0]  rank;
		logic               last;
		logic               full;
	} rank_word_t;

	typedef struct packed {
		logic [TOPC_W-1:0]  topc;
		logic [VAL_W-1:0]   value;
		logic               step;
		logic [19:0]        reps;
		logic               ns;
		logic               pinned;
		logic [VAL_W-1:0]   p_value;
		logic [COUNT_W-1:0] p_count;
		logic               p_full;
	} stim_row_t;

	// Pinned rows give the expected head of the ranking for the row's final word.
	localparam stim_row_t PLAN [0:PLAN_N-1] = '{
		'{4'd1,  16'h0000, 1'b0, 20'd1,     1'b0, 1'b1, 16'h0000, 16'd1,     1'b0},
		'{4'd1,  16'hFFFF, 1'b0, 20'd1,     1'b0, 1'b1, 16'h0000, 16'd1,     1'b0},
		'{4'd1,  16'hFFFF, 1'b0, 20'd1,     1'b0, 1'b1, 16'hFFFF, 16'd2,     1'b0},
		'{4'd8,  16'h1234, 1'b0, 20'd1,     1'b0, 1'b0, 16'h0000, 16'd0,     1'b0},
		'{4'd0,  16'h00FF, 1'b0, 20'd1,     1'b1, 1'b1, 16'h00FF, 16'd1,     1'b0},
		'{4'd15, 16'hAAAA, 1'b0, 20'd1,     1'b0, 1'b0, 16'h0000, 16'd0,     1'b0},
		'{4'd15, 16'h5555, 1'b0, 20'd1,     1'b0, 1'b0, 16'h0000, 16'd0,     1'b0},
		'{4'd15, 16'hAAAA, 1'b0, 20'd1,     1'b0, 1'b1, 16'hAAAA, 16'd2,     1'b0},
		'{4'd3,  16'h8001, 1'b0, 20'd1,     1'b1, 1'b0, 16'h0000, 16'd0,     1'b0},
		'{4'd3,  16'h8000, 1'b0, 20'd1,     1'b0, 1'b0, 16'h0000, 16'd0,     1'b0},
		'{4'd8,  16'h1000, 1'b1, 20'd64,    1'b1, 1'b1, 16'h1000, 16'd1,     1'b0},
		'{4'd8,  16'h2000, 1'b0, 20'd1,     1'b0, 1'b1, 16'h1000, 16'd1,     1'b1},
		'{4'd8,  16'h103F, 1'b0, 20'd1,     1'b0, 1'b1, 16'h103F, 16'd2,     1'b0},
		'{4'd8,  16'hFFFF, 1'b0, 20'd1,     1'b0, 1'b1, 16'h103F, 16'd2,     1'b1},
		'{4'd1,  16'h7E57, 1'b0, 20'd5,     1'b1, 1'b1, 16'h7E57, 16'd5,     1'b0},
		'{4'd2,  16'h7E57, 1'b0, 20'd1,     1'b0, 1'b1, 16'h7E57, 16'd6,     1'b0},
		'{4'd2,  16'h0001, 1'b0, 20'd1,     1'b0, 1'b0, 16'h0000, 16'd0,     1'b0}
	};

	logic               clk;
	logic               arst_n;
	logic               cfg_wen;
	logic [TOPC_W-1:0]  cfg_wdata;
	logic               sample_valid;
	logic               sample_stall;
	logic [VAL_W-1:0]   sample_value;
	logic               new_stream;
	logic               ranked_valid;
	logic               ranked_stall;
	logic [VAL_W-1:0]   ranked_value;
	logic [COUNT_W-1:0] ranked_count;
	logic [RANK_W-1:0]  rank;
	logic               last;
	logic               table_full;

	logic [VAL_W-1:0]   freq_value [ENTRIES];
	logic [COUNT_W-1:0] freq_count [ENTRIES];
	bit                 freq_used [ENTRIES];
	logic [TOPC_W-1:0]  freq_topc;

	rank_word_t pending_ranks [$];
	int         errors = 0;
	int         cycle_cnt = 0;
	int         burst_left = 0;
	bit         fast_mode = 0;
	bit         hold_off = 0;

	stream_top_k_frequent u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_value (sample_value),
		.new_stream   (new_stream),
		.ranked_valid (ranked_valid),
		.ranked_stall (ranked_stall),
		.ranked_value (ranked_value),
		.ranked_count (ranked_count),
		.rank         (rank),
		.last         (last),
		.table_full   (table_full)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic void queue_rank(input rank_word_t w);
		pending_ranks = {pending_ranks, w};
	endfunction

	// Counts one word in the frequency table and queues its ranking; returns the queue
	// position of the word's first result.
	function automatic int count_and_rank(input logic [VAL_W-1:0] v, input bit ns);
		int hit;
		int free_idx;
		int held;
		int want;
		int n;
		int best;
		int first;
		bit dropped;
		bit picked [ENTRIES];
		rank_word_t w;
		hit = -1;
		free_idx = -1;
		held = 0;
		dropped = 0;
		first = pending_ranks.size();
		if (ns) begin
			for (int i = 0; i < ENTRIES; i++) begin
				freq_used[i] = 0;
				freq_count[i] = '0;
			end
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (freq_used[i]) begin
				if (hit < 0 && freq_value[i] == v)
					hit = i;
			end else if (free_idx < 0) begin
				free_idx = i;
			end
		end
		if (hit >= 0) begin
			if (freq_count[hit] != COUNT_MAX)
				freq_count[hit] = freq_count[hit] + 1'b1;
		end else if (free_idx >= 0) begin
			freq_used[free_idx] = 1;
			freq_value[free_idx] = v;
			freq_count[free_idx] = COUNT_W'(1);
		end else begin
			dropped = 1;
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (freq_used[i])
				held++;
			picked[i] = 0;
		end
		want = (freq_topc == 0) ? 1 : int'(freq_topc);
		if (want > MAX_K)
			want = MAX_K;
		n = (held < want) ? held : want;
		for (int r = 0; r < n; r++) begin
			best = -1;
			for (int i = 0; i < ENTRIES; i++) begin
				if (freq_used[i] && !picked[i]) begin
					if (best < 0 || freq_count[i] > freq_count[best] ||
					    (freq_count[i] == freq_count[best] && freq_value[i] < freq_value[best]))
						best = i;
				end
			end
			picked[best] = 1;
			w.value = freq_value[best];
			w.count = freq_count[best];
			w.rank = RANK_W'(r);
			w.last = (r == n - 1);
			w.full = dropped;
			queue_rank(w);
		end
		return first;
	endfunction

	task automatic offer_word(input logic [VAL_W-1:0] v, input bit ns, output int first);
		int gap;
		if (!fast_mode && burst_left == 0) begin
			gap = $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				sample_valid = 1'b0;
				sample_value = VAL_W'($urandom);
				new_stream = 1'($urandom);
			end
			burst_left = $urandom_range(1, 40);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		sample_valid = 1'b1;
		sample_value = v;
		new_stream = ns;
		do @(posedge clk); while (sample_stall);
		first = count_and_rank(v, ns);
	endtask

	task automatic write_top_count(input logic [TOPC_W-1:0] tc);
		@(negedge clk);
		sample_valid = 1'b0;
		while (pending_ranks.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wen = 1'b1;
		cfg_wdata = tc;
		freq_topc = tc;
		@(negedge clk);
		cfg_wen = 1'b0;
	endtask

	always @(posedge clk) begin : check_ranks
		rank_word_t got_w;
		rank_word_t exp_w;
		if (arst_n && ranked_valid && !ranked_stall) begin
			got_w = '{ranked_value, ranked_count, rank, last, table_full};
			if (pending_ranks.size() == 0) begin
				errors++;
				if (errors <= SHOW_MAX)
					$display("Unexpected word at cycle %0d: value %h count %0d rank %0d last %b full %b",
					         cycle_cnt, got_w.value, got_w.count, got_w.rank, got_w.last,
					         got_w.full);
			end else begin
				exp_w = pending_ranks.pop_front();
				if (got_w !== exp_w) begin
					errors++;
					if (errors <= SHOW_MAX) begin
						$display("Mismatch at cycle %0d: expected value %h count %0d rank %0d",
						         cycle_cnt, exp_w.value, exp_w.count, exp_w.rank);
						$display("  expected last %b full %b, got value %h count %0d rank %0d",
						         exp_w.last, exp_w.full, got_w.value, got_w.count, got_w.rank);
						$display("  got last %b full %b", got_w.last, got_w.full);
					end
				end
			end
		end
	end

	initial begin : stall_pattern
		int mode;
		int left;
		bit stall;
		ranked_stall = 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				ranked_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off = 0;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(20, 150);
			end
			left--;
			case (mode)
				0: stall = 1'b0;
				1: stall = ($urandom_range(0, 3) == 0);
				default: stall = ($urandom_range(0, 3) != 0);
			endcase
			ranked_stall = fast_mode ? 1'b0 : stall;
		end
	end

	initial begin : stimulus
		logic [VAL_W-1:0] pool [256];
		logic [VAL_W-1:0] v;
		rank_word_t w;
		int first;
		int pool_n;
		int n_items;
		bit wide;
		bit ns;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		sample_valid = 1'b0;
		sample_value = '0;
		new_stream = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			freq_value[i] = '0;
			freq_count[i] = '0;
			freq_used[i] = 0;
		end
		freq_topc = TOPC_W'(1);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r < PLAN_N; r++) begin
			if (r == 0 || PLAN[r].topc != freq_topc)
				write_top_count(PLAN[r].topc);
			fast_mode = (PLAN[r].reps > 100);
			for (int i = 0; i < int'(PLAN[r].reps); i++) begin
				v = PLAN[r].value + (PLAN[r].step ? VAL_W'(i) : '0);
				offer_word(v, PLAN[r].ns && i == 0, first);
				if (PLAN[r].pinned && i == int'(PLAN[r].reps) - 1) begin
					w = pending_ranks[first];
					w.value = PLAN[r].p_value;
					w.count = PLAN[r].p_count;
					w.full = PLAN[r].p_full;
					pending_ranks[first] = w;
				end
			end
		end
		fast_mode = 0;

		for (int ph = 0; ph < 5; ph++) begin
			wide = (ph == 4);
			write_top_count(wide ? TOPC_W'(MAX_K) : TOPC_W'($urandom_range(0, 15)));
			case ($urandom_range(0, 2))
				0: pool_n = 3;
				1: pool_n = 10;
				default: pool_n = 40;
			endcase
			if (wide)
				pool_n = 200;
			for (int k = 0; k < pool_n; k++)
				pool[k] = VAL_W'($urandom_range(0, 65535));
			if (ph == 1)
				hold_off = 1;
			n_items = wide ? 70 : 40;
			for (int i = 0; i < n_items; i++) begin
				if (i == 0)
					ns = wide || ($urandom_range(0, 1) == 1);
				else
					ns = !wide && ($urandom_range(0, 49) == 0);
				offer_word(pool[$urandom_range(0, pool_n - 1)], ns, first);
			end
		end

		@(negedge clk);
		sample_valid = 1'b0;
		while (pending_ranks.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0 && pending_ranks.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[files.f]
hw/rtl/stkf_pkg.sv
hw/rtl/stkf_cell.sv
hw/rtl/stream_top_k_frequent.sv
tb/tb_top.sv
